>>> hw/rtl/wft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wft_pkg;
  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned MaxWordLenDef   = 49;
  localparam int unsigned CharW  = 8;
  localparam int unsigned IndexW = 6;
  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    StCollect,
    StSearch,
    StInsert,
    StOut
  } wft_state_e;
endpackage
`default_nettype wire

>>> hw/rtl/wft_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module wft_cell #(
  parameter int unsigned MaxWordLen = wft_pkg::MaxWordLenDef,
  parameter int unsigned LenW       = $clog2(MaxWordLen + 1)
) (
  input  wire                          clk_i,
  input  wire                          shift_i,
  input  wire                          load_i,
  input  wire                          bump_i,
  input  wire  [wft_pkg::CharW*MaxWordLen-1:0] word_i,
  input  wire  [LenW-1:0]              len_i,
  input  wire  [wft_pkg::CharW*MaxWordLen-1:0] word_prev_i,
  input  wire  [LenW-1:0]              len_prev_i,
  input  wire  [wft_pkg::CountW-1:0]   cnt_prev_i,
  output logic [wft_pkg::CharW*MaxWordLen-1:0] word_o,
  output logic [LenW-1:0]              len_o,
  output logic [wft_pkg::CountW-1:0]   cnt_o,
  output logic                         match_o
);
  import wft_pkg::*;

  logic [CharW*MaxWordLen-1:0] word_q;
  logic [LenW-1:0]             len_q;
  logic [CountW-1:0]           cnt_q;
  logic [CharW*MaxWordLen-1:0] mask;

  always_comb begin
    for (int i = 0; i < MaxWordLen; i++) begin
      mask[i*CharW +: CharW] = (LenW'(i) < len_i) ? '1 : '0;
    end
  end

  assign match_o = (len_q == len_i) && (((word_q ^ word_i) & mask) == '0);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
      len_q  <= len_i;
      cnt_q  <= CountW'(1);
    end else if (shift_i) begin
      word_q <= word_prev_i;
      len_q  <= len_prev_i;
      cnt_q  <= cnt_prev_i;
    end else if (bump_i && cnt_q != CountMax) begin
      cnt_q <= cnt_q + CountW'(1);
    end
  end

  assign word_o = word_q;
  assign len_o  = len_q;
  assign cnt_o  = cnt_q;
endmodule
`default_nettype wire

>>> hw/rtl/word_frequency_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Word frequency table.
// Input stream s_axis: one character per transfer, tlast on the word's last
// character. Characters inside a word are taken one per cycle; characters
// past the length limit are dropped and flagged.
// Output stream m_axis: one result per word, none for the other characters.
// At word end the stored entries rotate through a ring of cells, one entry
// per cycle, past a compare point at cell 0. The search turns the ring once
// round; on a hit the ring holds while the matching count advances. The
// search is then left for StInsert, which inserts a new word and registers
// the result, then StOut, which sets the output valid; s_axis_tready rises
// together with m_axis_tvalid.
// While a result waits for m_axis_tready, characters are still taken; a word
// end finishes its search and then holds until the output register is free.
// Reset empties the table and the word buffer; the table contents need no
// clearing pass since only filled entries are compared.
module word_frequency_table #(
  parameter int unsigned TABLE_ENTRIES = wft_pkg::TableEntriesDef,
  parameter int unsigned MAX_WORD_LEN  = wft_pkg::MaxWordLenDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,  // char_code
  input  wire         s_axis_tlast,  // word_end
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata   // entry_index, word_count, is_new, table_full, truncated
);
  import wft_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_WORD_LEN + 1);
  localparam int unsigned UseW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned PosW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned WordW = CharW * MAX_WORD_LEN;

  wft_state_e state_q, state_d;
  logic [WordW-1:0] buf_q;
  logic [LenW-1:0]  len_q;
  logic             ovf_q;
  logic [UseW-1:0]  used_q;
  logic [UseW-1:0]  step_q;
  logic [PosW-1:0]  head_q;
  logic             found_q;
  logic [IndexW-1:0] idx_q;
  logic [CountW-1:0] cnt_q;
  logic [31:0]      out_q;
  logic             out_vld_q;

  logic [WordW-1:0]  cw [TABLE_ENTRIES];
  logic [LenW-1:0]   cl [TABLE_ENTRIES];
  logic [CountW-1:0] cc [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] cm;
  logic shift, load, bump, acc, hit;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign hit = (step_q < used_q) && cm[0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      StCollect: if (acc && s_axis_tlast) state_d = StSearch;
      StSearch: begin
        if (step_q == UseW'(TABLE_ENTRIES) && (!out_vld_q || m_axis_tready))
          state_d = StInsert;
      end
      StInsert:  state_d = StOut;
      StOut:     state_d = StCollect;
      default:   state_d = StCollect;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == StCollect);
    shift = (state_q == StSearch) && (step_q != UseW'(TABLE_ENTRIES));
    bump  = shift && hit && !found_q;
    load  = (state_q == StInsert) && !found_q && (used_q != UseW'(TABLE_ENTRIES));
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    localparam int unsigned Nx = (g + 1) % TABLE_ENTRIES;
    wft_cell #(.MaxWordLen(MAX_WORD_LEN), .LenW(LenW)) u_cell (
      .clk_i,
      .shift_i(shift && !bump),
      .load_i(load && (g == int'(used_q))),
      .bump_i(bump && g == 0),
      .word_i(buf_q), .len_i(len_q),
      .word_prev_i(cw[Nx]), .len_prev_i(cl[Nx]), .cnt_prev_i(cc[Nx]),
      .word_o(cw[g]), .len_o(cl[g]), .cnt_o(cc[g]), .match_o(cm[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StCollect;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      used_q    <= '0;
      step_q    <= '0;
      head_q    <= '0;
      found_q   <= 1'b0;
      idx_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut) out_vld_q <= 1'b1;
      else if (out_vld_q && m_axis_tready) out_vld_q <= 1'b0;
      case (state_q)
        StCollect: begin
          if (acc) begin
            if (len_q != LenW'(MAX_WORD_LEN)) len_q <= len_q + LenW'(1);
            else ovf_q <= 1'b1;
            step_q  <= '0;
            head_q  <= '0;
            found_q <= 1'b0;
          end
        end
        StSearch: begin
          if (bump) begin
            found_q <= 1'b1;
            idx_q   <= IndexW'(head_q);
            cnt_q   <= (cc[0] != CountMax) ? cc[0] + CountW'(1) : cc[0];
          end
          if (shift && !bump) begin
            step_q <= step_q + UseW'(1);
            head_q <= (head_q == PosW'(TABLE_ENTRIES - 1)) ? '0 : head_q + PosW'(1);
          end
        end
        StInsert: begin
          if (load) used_q <= used_q + UseW'(1);
        end
        StOut: begin
          len_q <= '0;
          ovf_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Collect characters; register the result once the search is done.
  always_ff @(posedge clk_i) begin
    if (acc && len_q != LenW'(MAX_WORD_LEN))
      buf_q[CharW*len_q +: CharW] <= s_axis_tdata;
    if (state_q == StInsert) begin
      if (found_q)
        out_q <= {7'b0, ovf_q, 1'b0, 1'b0, cnt_q, idx_q};
      else if (load)
        out_q <= {7'b0, ovf_q, 1'b0, 1'b1, CountW'(1), IndexW'(used_q)};
      else
        out_q <= {7'b0, ovf_q, 1'b1, 1'b0, CountW'(0), IndexW'(0)};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> used_q < UseW'(TABLE_ENTRIES)) else $error("insert into full table");
  a_used_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q >= $past(used_q)) else $error("entry count dropped");
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StCollect |-> !s_axis_tready) else $error("input taken during search");
endmodule
`default_nettype wire
